// ----- hdl/cscf_pkg.sv -----
// Shared types and constants for the comment-stripping character filter.
package cscf_pkg;

    // Character codes
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Lexer modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_STRING = 3'd1;
    localparam logic [2:0] MODE_CHAR   = 3'd2;
    localparam logic [2:0] MODE_SLASH  = 3'd3;
    localparam logic [2:0] MODE_LINE   = 3'd4;
    localparam logic [2:0] MODE_BLOCK  = 3'd5;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } result_t;

    // One queued entry: one or two output characters
    typedef struct packed {
        logic       two;
        logic [7:0] c0;
        logic [7:0] c1;
    } q_entry_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic     avail;
        q_entry_t entry;
    } q_head_t;

endpackage

// ----- hdl/cscf_front.sv -----
// Front end: mode tracking and classification of each input byte.
module cscf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            full,
    input  cscf_pkg::item_t item,
    output logic            item_stall,
    output logic            push,
    output cscf_pkg::q_entry_t push_entry
);
    import cscf_pkg::*;

    logic [2:0] mode_reg, mode_next;
    logic       str_esc_reg, str_esc_next;
    logic       chr_esc_reg, chr_esc_next;
    logic       line_esc_reg, line_esc_next;
    logic       star_reg, star_next;

    logic       raw_a_valid, raw_b_valid;
    logic [7:0] raw_b;
    logic       kept_a, kept_b;
    logic       accept;
    logic [7:0] c;

    function automatic logic is_blank(input logic [7:0] ch);
        is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
    endfunction

    function automatic logic [7:0] outside_map(input logic [7:0] ch);
        if (ch == CH_NL)
            outside_map = CH_SPACE;
        else if (ch == CH_SEMI)
            outside_map = CH_NL;
        else
            outside_map = ch;
    endfunction

    assign item_stall = full;
    assign accept     = item_valid && !full;
    assign c          = item.char_code;

    always_comb
    begin
        mode_next     = mode_reg;
        str_esc_next  = str_esc_reg;
        chr_esc_next  = chr_esc_reg;
        line_esc_next = line_esc_reg;
        star_next     = star_reg;
        raw_a_valid   = 1'b0;   // slot a only ever carries a held slash
        raw_b_valid   = 1'b0;
        raw_b         = c;
        if (item.op == OP_END)
        begin
            raw_a_valid   = (mode_reg == MODE_SLASH);
            raw_b_valid   = 1'b1;
            raw_b         = CH_NL;
            mode_next     = MODE_NORMAL;
            str_esc_next  = 1'b0;
            chr_esc_next  = 1'b0;
            line_esc_next = 1'b0;
            star_next     = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_STRING:
                begin
                    raw_b_valid  = 1'b1;
                    if (c == CH_DQUOTE && !str_esc_reg)
                        mode_next = MODE_NORMAL;
                    str_esc_next = (c == CH_BSLASH) && !str_esc_reg;
                end
                MODE_CHAR:
                begin
                    raw_b_valid  = 1'b1;
                    if (c == CH_SQUOTE && !chr_esc_reg)
                        mode_next = MODE_NORMAL;
                    chr_esc_next = (c == CH_BSLASH) && !chr_esc_reg;
                end
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (c == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                    begin
                        // lone slash: release it, then treat byte as normal text
                        raw_a_valid = 1'b1;
                        raw_b_valid = 1'b1;
                        raw_b       = outside_map(c);
                        if (c == CH_DQUOTE)
                            mode_next = MODE_STRING;
                        else if (c == CH_SQUOTE)
                            mode_next = MODE_CHAR;
                        else
                            mode_next = MODE_NORMAL;
                    end
                end
                MODE_LINE:
                begin
                    // exit stands for a space, which is dropped
                    if (c == CH_NL && !line_esc_reg)
                        mode_next = MODE_NORMAL;
                    line_esc_next = (c == CH_BSLASH) && !line_esc_reg;
                end
                MODE_BLOCK:
                begin
                    if (c == CH_SLASH && star_reg)
                        mode_next = MODE_NORMAL;
                    star_next = (c == CH_STAR);
                end
                default:
                begin
                    if (c == CH_SLASH)
                        mode_next = MODE_SLASH;
                    else
                    begin
                        raw_b_valid = 1'b1;
                        raw_b       = outside_map(c);
                        if (c == CH_DQUOTE)
                            mode_next = MODE_STRING;
                        else if (c == CH_SQUOTE)
                            mode_next = MODE_CHAR;
                        else
                            mode_next = MODE_NORMAL;
                    end
                end
            endcase
        end
    end

    assign kept_a = raw_a_valid;
    assign kept_b = raw_b_valid && !is_blank(raw_b);

    always_comb
    begin
        push_entry.c1 = raw_b;
        if (kept_a)
        begin
            push_entry.c0  = CH_SLASH;
            push_entry.two = kept_b;
        end
        else
        begin
            push_entry.c0  = raw_b;
            push_entry.two = 1'b0;
        end
    end

    assign push = accept && (kept_a || kept_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NORMAL;
            str_esc_reg  <= 1'b0;
            chr_esc_reg  <= 1'b0;
            line_esc_reg <= 1'b0;
            star_reg     <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            str_esc_reg  <= str_esc_next;
            chr_esc_reg  <= chr_esc_next;
            line_esc_reg <= line_esc_next;
            star_reg     <= star_next;
        end
    end

endmodule

// ----- hdl/cscf_queue.sv -----
// Short queue of pending output entries between front and back end.
module cscf_queue #(
    parameter int DEPTH = cscf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cscf_pkg::q_entry_t  push_entry,
    input  logic                pop,
    output logic                full,
    output cscf_pkg::q_head_t   head
);
    import cscf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);

    assign head.avail = (count_reg != '0);
    assign head.entry = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/cscf_back.sv -----
// Back end: serialises queued entries into result transactions.
module cscf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cscf_pkg::q_head_t  head,
    input  logic               result_stall,
    output logic               pop,
    output logic               result_valid,
    output cscf_pkg::result_t  result
);
    import cscf_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;
    logic    phase_reg, phase_next;   // first of a pair already sent
    logic    load;
    logic    first_of_two;

    assign load         = !valid_reg || !result_stall;
    assign first_of_two = head.entry.two && !phase_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = head.avail;
            if (head.avail)
            begin
                if (first_of_two)
                begin
                    data_next.out_char = head.entry.c0;
                    data_next.last     = 1'b0;
                    phase_next         = 1'b1;
                end
                else
                begin
                    data_next.out_char = phase_reg ? head.entry.c1 : head.entry.c0;
                    data_next.last     = 1'b1;
                    phase_next         = 1'b0;
                    pop                = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// ----- hdl/comment_stripping_char_filter.sv -----
// Comment-stripping character filter: top level.
// Path of a result: the entry queue, then the output register.
// Input takes one byte per cycle unless the queue is full; a byte yielding two
// results (held slash plus byte) sends them in turn via the single output register.
// Input stalls only while the entry queue (QUEUE_DEPTH entries) is full.
// Reset (rst_n low, asynchronous): normal mode, all flags clear, queue empty.
module comment_stripping_char_filter #(
    parameter int QUEUE_DEPTH = cscf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cscf_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output cscf_pkg::result_t result
);
    import cscf_pkg::*;

    // Front end -> queue
    logic     push;
    q_entry_t push_entry;
    logic     full;

    // Queue -> back end
    q_head_t  head;
    logic     pop;

    // Front end: tracks the lexer mode and turns each byte into zero, one
    // or two output characters, blanks already removed.
    cscf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .full       (full),
        .item       (item),
        .item_stall (item_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue decouples the stall of the result side from the input side.
    cscf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head       (head)
    );

    // Back end: one result transaction per cycle while the queue holds entries and the
    // result side does not stall; last set on the final character of each entry.
    cscf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .result_stall (result_stall),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- hdl/cscf_checker.sv -----
// Port-level checks for the comment-stripping character filter, with bind.
module cscf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input cscf_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input cscf_pkg::result_t result
);
    import cscf_pkg::*;

    // A stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("input changed while stalled");

    // A stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Blanks never reach the output
    a_no_blank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_char != CH_SPACE) && (result.out_char != CH_TAB))
        else $error("blank character emitted");

    // Pairs only come from a released slash
    a_pair_slash: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.out_char == CH_SLASH)
        else $error("first of a pair is not a slash");

    // Second of a pair follows at once
    a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=> result_valid)
        else $error("second of a pair missing");

endmodule

bind comment_stripping_char_filter cscf_checker u_cscf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- verif/tb_comment_stripping_char_filter.sv -----
// Self-checking testbench for the comment-stripping character filter.
`timescale 1ns / 1ps

module tb_comment_stripping_char_filter;

    import cscf_pkg::*;

    // Run shape
    localparam int N_RANDOM     = 1300;  // random byte-level transactions
    localparam int QUIET_TAIL   = 150;   // final transactions sent with no idling
    localparam int DRAIN_CYCLES = 16;    // extra wait once all owed results are out
    localparam int WATCHDOG_MAX = 1000;  // cycles with no transaction on either side
    localparam int PREDICT      = -1;    // table row has no typed-in result

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    comment_stripping_char_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Filter state as the testbench sees it
    // ------------------------------------------------------------------
    logic [2:0] lex_mode;
    bit         str_esc;     // backslash pending inside a string literal
    bit         chr_esc;     // backslash pending inside a char literal
    bit         line_esc;    // backslash pending inside a line comment
    bit         star_seen;   // last block-comment byte was a star

    logic [7:0] step_chars[$];   // characters produced by the current byte
    result_t    owed_chars[$];   // results still to come out of the block

    int  errors;
    bit  quiet;                  // tail of the run: no idling on either side

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns  %s: got %02h, expected %02h", $time, what, got, want);
        errors++;
    endtask

    function automatic void clear_filter();
        lex_mode  = MODE_NORMAL;
        str_esc   = 1'b0;
        chr_esc   = 1'b0;
        line_esc  = 1'b0;
        star_seen = 1'b0;
    endfunction

    // Blanks never leave the block, whatever mode they come from
    function automatic void emit_char(input logic [7:0] c);
        if (c != CH_SPACE && c != CH_TAB && step_chars.size() < 2)
            step_chars = {step_chars, c};
    endfunction

    // Outside quotes: newline reads as a blank, semicolon ends a line
    function automatic logic [7:0] outside_map(input logic [7:0] c);
        if (c == CH_NL)
            return CH_SPACE;
        if (c == CH_SEMI)
            return CH_NL;
        return c;
    endfunction

    function automatic void normal_char(input logic [7:0] c);
        if (c == CH_SLASH)
            lex_mode = MODE_SLASH;
        else
        begin
            if (c == CH_DQUOTE)
                lex_mode = MODE_STRING;
            else if (c == CH_SQUOTE)
                lex_mode = MODE_CHAR;
            emit_char(outside_map(c));
        end
    endfunction

    // Works out the characters one transaction yields and moves the state on
    function automatic void strip_byte(input item_t it);
        logic [7:0] c;
        c = it.char_code;
        step_chars.delete();
        if (it.op == OP_END)
        begin
            // a slash held back from the previous byte goes out first
            if (lex_mode == MODE_SLASH)
                emit_char(CH_SLASH);
            emit_char(CH_NL);
            clear_filter();
        end
        else
        begin
            case (lex_mode)
                MODE_STRING:
                begin
                    emit_char(c);
                    if (c == CH_DQUOTE && !str_esc)
                        lex_mode = MODE_NORMAL;
                    str_esc = (c == CH_BSLASH) && !str_esc;
                end
                MODE_CHAR:
                begin
                    emit_char(c);
                    if (c == CH_SQUOTE && !chr_esc)
                        lex_mode = MODE_NORMAL;
                    chr_esc = (c == CH_BSLASH) && !chr_esc;
                end
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                        lex_mode = MODE_LINE;
                    else if (c == CH_STAR)
                        lex_mode = MODE_BLOCK;
                    else
                    begin
                        // lone slash: release it, then treat the byte as plain text
                        emit_char(CH_SLASH);
                        lex_mode = MODE_NORMAL;
                        normal_char(c);
                    end
                end
                MODE_LINE:
                begin
                    if (c == CH_NL && !line_esc)
                    begin
                        emit_char(outside_map(c));
                        lex_mode = MODE_NORMAL;
                    end
                    line_esc = (c == CH_BSLASH) && !line_esc;
                end
                MODE_BLOCK:
                begin
                    // the closing star-slash stands for a blank, which is dropped
                    if (c == CH_SLASH && star_seen)
                    begin
                        emit_char(CH_SPACE);
                        lex_mode = MODE_NORMAL;
                    end
                    star_seen = (c == CH_STAR);
                end
                default:
                begin
                    lex_mode = MODE_NORMAL;
                    normal_char(c);
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random C-like text
    // ------------------------------------------------------------------
    typedef struct {
        item_t      it;
        int         typed_n;     // PREDICT, or the number of typed-in results
        logic [7:0] typed_char;
    } dir_row_t;

    dir_row_t dir_rows[$];
    item_t    text_items[$];

    task automatic add_row(input logic op, input logic [7:0] c, input int n,
                           input logic [7:0] t);
        dir_row_t row;
        row.it.op        = op;
        row.it.char_code = c;
        row.typed_n      = n;
        row.typed_char   = t;
        dir_rows = {dir_rows, row};
    endtask

    task automatic add_text(input logic [7:0] c);
        item_t it;
        it.op        = OP_BYTE;
        it.char_code = c;
        text_items = {text_items, it};
    endtask

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(0, 8))
            0:       return CH_DQUOTE;
            1:       return CH_SQUOTE;
            2:       return CH_SLASH;
            3:       return CH_STAR;
            4:       return CH_SEMI;
            5:       return CH_NL;
            6:       return CH_TAB;
            7:       return CH_BSLASH;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] any_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return letter();
        if (r < 75)
            return punct_char();
        return 8'($urandom_range(0, 255));
    endfunction

    // Appends one lexical fragment; mostly well formed, with some noise
    task automatic add_fragment();
        int         kind;
        int         len;
        item_t      it;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(0, 8);
        if (kind < 22)
        begin
            repeat (len + 1) add_text(letter());
        end
        else if (kind < 36)
        begin
            add_text(any_char());
        end
        else if (kind < 50)
        begin
            // string literal, blanks and escapes inside
            add_text(CH_DQUOTE);
            repeat (len)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    add_text(CH_BSLASH);
                    add_text(any_char());
                end
                else
                    add_text($urandom_range(0, 1) ? letter() : punct_char());
            end
            add_text(CH_DQUOTE);
        end
        else if (kind < 58)
        begin
            add_text(CH_SQUOTE);
            if ($urandom_range(0, 2) == 0)
                add_text(CH_BSLASH);
            add_text(any_char());
            add_text(CH_SQUOTE);
        end
        else if (kind < 70)
        begin
            // line comment, sometimes continued past a newline by a backslash
            add_text(CH_SLASH);
            add_text(CH_SLASH);
            repeat (len)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    add_text(CH_BSLASH);
                    add_text(CH_NL);
                end
                else
                    add_text(any_char());
            end
            add_text(CH_NL);
        end
        else if (kind < 82)
        begin
            add_text(CH_SLASH);
            add_text(CH_STAR);
            repeat (len) add_text($urandom_range(0, 2) == 0 ? CH_STAR : any_char());
            add_text(CH_STAR);
            add_text(CH_SLASH);
        end
        else if (kind < 89)
        begin
            add_text(CH_SLASH);
            add_text(any_char());
        end
        else if (kind < 97)
        begin
            add_text(8'($urandom_range(0, 255)));
        end
        else
        begin
            it.op        = OP_END;
            it.char_code = 8'($urandom_range(0, 255));
            text_items = {text_items, it};
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: idles in bursts, holds the payload while stalled
    // ------------------------------------------------------------------
    task automatic send_byte(input item_t it, input int typed_n, input logic [7:0] typed_char);
        result_t r;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // transaction accepted at this edge
        strip_byte(it);
        if (typed_n != PREDICT)
        begin
            step_chars.delete();
            if (typed_n == 1)
                step_chars = {step_chars, typed_char};
        end
        for (int k = 0; k < step_chars.size(); k++)
        begin
            r.out_char = step_chars[k];
            r.last     = (k == step_chars.size() - 1);
            owed_chars = {owed_chars, r};
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls in bursts, none in the quiet tail
    // ------------------------------------------------------------------
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Checker: each result against the oldest owed one
    result_t want;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (owed_chars.size() == 0)
                report_mismatch("result with nothing owed", result.out_char, 0);
            else
            begin
                want = owed_chars.pop_front();
                if (result.out_char !== want.out_char)
                    report_mismatch("out_char", result.out_char, want.out_char);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
            end
        end
    end

    // Watchdog: too long without any transaction means the block has hung
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("comment_stripping_char_filter: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        errors     = 0;
        quiet      = 1'b0;
        clear_filter();

        // directed table: extremes, blanks, mapping, each mode and its way out
        add_row(OP_END,  8'h00,     1,       CH_NL);    // end straight after reset
        add_row(OP_BYTE, 8'h00,     1,       8'h00);
        add_row(OP_BYTE, 8'hFF,     1,       8'hFF);
        add_row(OP_BYTE, CH_SPACE,  0,       8'h00);
        add_row(OP_BYTE, CH_TAB,    0,       8'h00);
        add_row(OP_BYTE, CH_NL,     0,       8'h00);    // newline maps to a dropped blank
        add_row(OP_BYTE, CH_SEMI,   1,       CH_NL);
        add_row(OP_BYTE, CH_SLASH,  PREDICT, 8'h00);    // lone slash released with 'a'
        add_row(OP_BYTE, 8'h61,     PREDICT, 8'h00);
        add_row(OP_BYTE, CH_SLASH,  PREDICT, 8'h00);    // line comment
        add_row(OP_BYTE, CH_SLASH,  PREDICT, 8'h00);
        add_row(OP_BYTE, CH_BSLASH, PREDICT, 8'h00);
        add_row(OP_BYTE, CH_NL,     PREDICT, 8'h00);    // escaped: comment goes on
        add_row(OP_BYTE, CH_NL,     PREDICT, 8'h00);    // comment exit
        add_row(OP_BYTE, CH_SLASH,  PREDICT, 8'h00);    // block comment, double star
        add_row(OP_BYTE, CH_STAR,   PREDICT, 8'h00);
        add_row(OP_BYTE, CH_STAR,   PREDICT, 8'h00);
        add_row(OP_BYTE, CH_SLASH,  PREDICT, 8'h00);
        add_row(OP_BYTE, CH_DQUOTE, PREDICT, 8'h00);    // string with escaped quote
        add_row(OP_BYTE, CH_BSLASH, PREDICT, 8'h00);
        add_row(OP_BYTE, CH_DQUOTE, PREDICT, 8'h00);
        add_row(OP_BYTE, CH_DQUOTE, PREDICT, 8'h00);
        add_row(OP_BYTE, CH_SQUOTE, PREDICT, 8'h00);    // char literal, semicolon kept
        add_row(OP_BYTE, CH_SEMI,   PREDICT, 8'h00);
        add_row(OP_BYTE, CH_SQUOTE, PREDICT, 8'h00);
        add_row(OP_BYTE, CH_SLASH,  PREDICT, 8'h00);    // slash held over an end
        add_row(OP_END,  8'hA5,     PREDICT, 8'h00);

        while (text_items.size() < N_RANDOM)
            add_fragment();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].it, dir_rows[i].typed_n, dir_rows[i].typed_char);

        foreach (text_items[i])
        begin
            if (i >= text_items.size() - QUIET_TAIL)
                quiet = 1'b1;
            send_byte(text_items[i], PREDICT, 8'h00);
        end

        @(negedge clk);
        item_valid <= 1'b0;

        // drain; the watchdog bounds this wait
        while (owed_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("comment_stripping_char_filter: match");
        else
            $display("comment_stripping_char_filter: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/cscf_pkg.sv
hdl/cscf_front.sv
hdl/cscf_queue.sv
hdl/cscf_back.sv
hdl/comment_stripping_char_filter.sv
hdl/cscf_checker.sv
verif/tb_comment_stripping_char_filter.sv
